### sv/isfp_pkg.sv
// isfp_pkg: shared constants and helpers for the serial frame parser.
// Holds frame event codes, register indexes, header bytes and widths.
// No dependencies.
`default_nettype none

package isfp_pkg;

   // Frame position counter width and payload field widths
   localparam int POS_W  = 9;
   localparam int BYTE_W = 8;
   localparam int EVT_W  = 3;

   // Configuration port geometry
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_SERIAL_VERSION = 2'd0;
   localparam logic [1:0] REG_RPC_TYPE_CODE  = 2'd1;
   localparam logic [1:0] REG_WIFI_SETTINGS  = 2'd2;

   // Register reset values
   localparam logic [BYTE_W-1:0] SERIAL_VERSION_RST = 8'd1;
   localparam logic [BYTE_W-1:0] RPC_TYPE_CODE_RST  = 8'd3;
   localparam logic [BYTE_W-1:0] WIFI_SETTINGS_RST  = 8'd1;

   // Frame end events
   localparam logic [EVT_W-1:0] EVT_NONE      = 3'd0;
   localparam logic [EVT_W-1:0] EVT_RPC_OK    = 3'd1;
   localparam logic [EVT_W-1:0] EVT_CSUM_ERR  = 3'd2;
   localparam logic [EVT_W-1:0] EVT_OTHER_OK  = 3'd3;
   localparam logic [EVT_W-1:0] EVT_RPC_BADLEN = 3'd4;
   localparam logic [EVT_W-1:0] EVT_TOO_LONG  = 3'd5;

   // Frame layout positions
   localparam logic [POS_W-1:0] POS_VERSION = 9'd6;
   localparam logic [POS_W-1:0] POS_TYPE    = 9'd7;
   localparam logic [POS_W-1:0] POS_LENGTH  = 9'd8;
   localparam logic [POS_W-1:0] POS_PAYLOAD = 9'd9;

   // Payload offsets with fixed captures
   localparam logic [POS_W-1:0] OFF_COMMAND   = 9'd0;
   localparam logic [POS_W-1:0] OFF_INNER_LEN = 9'd1;
   localparam logic [POS_W-1:0] OFF_SSID_LEN  = 9'd2;
   localparam logic [POS_W-1:0] OFF_PASS_BASE = 9'd3;

   localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;

   // Header sequence "IMPROV"
   function automatic logic [BYTE_W-1:0] header_byte(input logic [2:0] idx);
      logic [BYTE_W-1:0] hb;
      case (idx)
         3'd0:    hb = 8'h49; // I
         3'd1:    hb = 8'h4D; // M
         3'd2:    hb = 8'h50; // P
         3'd3:    hb = 8'h52; // R
         3'd4:    hb = 8'h4F; // O
         3'd5:    hb = 8'h56; // V
         default: hb = BYTE_ZERO;
      endcase
      return hb;
   endfunction

endpackage

`default_nettype wire

### sv/improv_serial_frame_parser.sv
// improv_serial_frame_parser: byte-serial IMPROV frame parser, top level.
// Depends on isfp_pkg for event codes, register indexes and header bytes.
// Input register, one stage of per-byte logic, result register.
//
// Usage
//   req channel: one received serial byte per transfer (req_rx_byte).
//   rsp channel: exactly one result per byte, in order: accept flag, frame
//     event, captured type/command/ssid/password lengths, payload tag.
//   APB port: serial_version (0x0), rpc_type_code (0x4),
//     wifi_settings_code (0x8); write only while no byte is in flight.
// Timing
//   A byte taken is registered in the input stage; the parse step runs
//   between that register and the result register, which latches the
//   result when nothing stalls. Throughput is one byte per cycle while
//   nothing stalls: the frame state (position, running sum, captured
//   bytes) updates in the same cycle the result is latched.
// Reset
//   Synchronous, active high. Both stages empty, position and captures
//   zero, registers back to version 1, RPC type 3, WiFi settings 1.
// Back-pressure
//   rsp_stall holds the result register. The input stage still takes one
//   more byte while a result waits; req_stall rises only when both stages
//   are full and the result is stalled.
`default_nettype none

module improv_serial_frame_parser
   import isfp_pkg::*;
#(
   parameter int MAX_FRAME = 100
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // APB configuration port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   // byte input channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [BYTE_W-1:0]     req_rx_byte,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_accepted,
   output logic      [EVT_W-1:0]      rsp_frame_event,
   output logic      [BYTE_W-1:0]     rsp_frame_kind,
   output logic      [BYTE_W-1:0]     rsp_rpc_command,
   output logic                       rsp_payload_valid,
   output logic      [BYTE_W-1:0]     rsp_payload_offset,
   output logic                       rsp_is_wifi_settings,
   output logic      [BYTE_W-1:0]     rsp_ssid_len,
   output logic      [BYTE_W-1:0]     rsp_pass_len
);

   localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_FRAME);
   localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [BYTE_W-1:0] serial_version_ff;
   logic [BYTE_W-1:0] rpc_type_code_ff;
   logic [BYTE_W-1:0] wifi_settings_ff;
   logic              csr_wr;
   logic [1:0]        csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         serial_version_ff <= SERIAL_VERSION_RST;
         rpc_type_code_ff  <= RPC_TYPE_CODE_RST;
         wifi_settings_ff  <= WIFI_SETTINGS_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_SERIAL_VERSION: serial_version_ff <= pwdata[BYTE_W-1:0];
            REG_RPC_TYPE_CODE:  rpc_type_code_ff  <= pwdata[BYTE_W-1:0];
            REG_WIFI_SETTINGS:  wifi_settings_ff  <= pwdata[BYTE_W-1:0];
            default: ; // unmapped address, write dropped
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_SERIAL_VERSION: prdata = {{(CSR_DATA_W-BYTE_W){1'b0}}, serial_version_ff};
         REG_RPC_TYPE_CODE:  prdata = {{(CSR_DATA_W-BYTE_W){1'b0}}, rpc_type_code_ff};
         REG_WIFI_SETTINGS:  prdata = {{(CSR_DATA_W-BYTE_W){1'b0}}, wifi_settings_ff};
         default:            prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Handshake: input stage and result stage
   // ---------------------------------------------------------------
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              rsp_valid_ff;
   logic              req_xfer;
   logic              advance;

   // input stage moves on when the result register is empty or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_xfer  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_xfer)
            in_valid_ff <= 1'b1;
         else if (advance)
            in_valid_ff <= 1'b0;
         if (advance)
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer)
         in_byte_ff <= req_rx_byte;
   end

   // ---------------------------------------------------------------
   // Frame state
   // ---------------------------------------------------------------
   logic [POS_W-1:0]  pos_ff,      pos_in;
   logic [BYTE_W-1:0] sum_ff,      sum_in;
   logic [BYTE_W-1:0] kind_ff,     kind_in;
   logic [BYTE_W-1:0] length_ff,   length_in;
   logic [BYTE_W-1:0] command_ff,  command_in;
   logic [BYTE_W-1:0] inner_ff,    inner_in;
   logic [BYTE_W-1:0] ssid_ff,     ssid_in;
   logic [BYTE_W-1:0] pass_ff,     pass_in;

   // per-byte result, before the result register
   logic              acc_in;
   logic [EVT_W-1:0]  evt_in;
   logic              pvalid_in;
   logic [BYTE_W-1:0] poff_in;
   logic              wifi_in;

   logic [POS_W-1:0]  off;
   logic [POS_W-1:0]  payload_end;
   logic [POS_W-1:0]  pass_off;
   logic [BYTE_W-1:0] b;
   logic [BYTE_W-1:0] sum_base;
   logic              len_ok;

   assign b           = in_byte_ff;
   assign off         = pos_ff - POS_PAYLOAD;
   assign payload_end = POS_LENGTH + {1'b0, length_ff};
   assign pass_off    = OFF_PASS_BASE + {1'b0, ssid_ff};
   // RPC inner length must equal outer length minus command and length bytes
   assign len_ok      = (length_ff >= 8'd2) && (inner_ff == (length_ff - 8'd2));

   always_comb begin
      pos_in     = pos_ff;
      sum_in     = sum_ff;
      kind_in    = kind_ff;
      length_in  = length_ff;
      command_in = command_ff;
      inner_in   = inner_ff;
      ssid_in    = ssid_ff;
      pass_in    = pass_ff;
      acc_in     = 1'b0;
      evt_in     = EVT_NONE;
      pvalid_in  = 1'b0;
      poff_in    = BYTE_ZERO;
      wifi_in    = 1'b0;
      sum_base   = sum_ff;

      if (pos_ff >= MAX_POS) begin
         // ran past frame capacity: drop and rehunt
         evt_in = EVT_TOO_LONG;
         pos_in = '0;
      end else if (pos_ff < POS_VERSION) begin
         if (b == header_byte(pos_ff[2:0])) begin
            if (pos_ff == '0) begin
               // new frame start clears captures and checksum
               sum_base   = BYTE_ZERO;
               kind_in    = BYTE_ZERO;
               length_in  = BYTE_ZERO;
               command_in = BYTE_ZERO;
               inner_in   = BYTE_ZERO;
               ssid_in    = BYTE_ZERO;
               pass_in    = BYTE_ZERO;
            end
            sum_in = sum_base + b;
            acc_in = 1'b1;
            pos_in = pos_ff + POS_ONE;
         end else begin
            pos_in = '0;
         end
      end else if (pos_ff == POS_VERSION) begin
         if (b == serial_version_ff) begin
            sum_in = sum_ff + b;
            acc_in = 1'b1;
            pos_in = POS_TYPE;
         end else begin
            pos_in = '0;
         end
      end else if (pos_ff <= POS_LENGTH) begin
         if (pos_ff == POS_TYPE)
            kind_in = b;
         else
            length_in = b;
         sum_in = sum_ff + b;
         acc_in = 1'b1;
         pos_in = pos_ff + POS_ONE;
      end else if (pos_ff <= payload_end) begin
         if (off == OFF_COMMAND)
            command_in = b;
         else if (off == OFF_INNER_LEN)
            inner_in = b;
         else if (off == OFF_SSID_LEN)
            ssid_in = b;
         else if (off == pass_off)
            pass_in = b;
         sum_in    = sum_ff + b;
         acc_in    = 1'b1;
         pvalid_in = 1'b1;
         poff_in   = off[BYTE_W-1:0];
         pos_in    = pos_ff + POS_ONE;
      end else begin
         // checksum byte closes the frame either way
         if (sum_ff != b) begin
            evt_in = EVT_CSUM_ERR;
         end else begin
            acc_in = 1'b1;
            if (kind_ff == rpc_type_code_ff) begin
               if (len_ok) begin
                  evt_in  = EVT_RPC_OK;
                  wifi_in = (command_ff == wifi_settings_ff);
               end else begin
                  evt_in = EVT_RPC_BADLEN;
               end
            end else begin
               evt_in = EVT_OTHER_OK;
            end
         end
         pos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         sum_ff     <= '0;
         kind_ff    <= '0;
         length_ff  <= '0;
         command_ff <= '0;
         inner_ff   <= '0;
         ssid_ff    <= '0;
         pass_ff    <= '0;
      end else if (advance) begin
         pos_ff     <= pos_in;
         sum_ff     <= sum_in;
         kind_ff    <= kind_in;
         length_ff  <= length_in;
         command_ff <= command_in;
         inner_ff   <= inner_in;
         ssid_ff    <= ssid_in;
         pass_ff    <= pass_in;
      end
   end

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   logic              r_acc_ff;
   logic [EVT_W-1:0]  r_evt_ff;
   logic [BYTE_W-1:0] r_kind_ff;
   logic [BYTE_W-1:0] r_cmd_ff;
   logic              r_pvalid_ff;
   logic [BYTE_W-1:0] r_poff_ff;
   logic              r_wifi_ff;
   logic [BYTE_W-1:0] r_ssid_ff;
   logic [BYTE_W-1:0] r_pass_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         r_acc_ff    <= acc_in;
         r_evt_ff    <= evt_in;
         r_kind_ff   <= kind_in;
         r_cmd_ff    <= command_in;
         r_pvalid_ff <= pvalid_in;
         r_poff_ff   <= poff_in;
         r_wifi_ff   <= wifi_in;
         r_ssid_ff   <= ssid_in;
         r_pass_ff   <= pass_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_accepted         = r_acc_ff;
   assign rsp_frame_event      = r_evt_ff;
   assign rsp_frame_kind       = r_kind_ff;
   assign rsp_rpc_command      = r_cmd_ff;
   assign rsp_payload_valid    = r_pvalid_ff;
   assign rsp_payload_offset   = r_poff_ff;
   assign rsp_is_wifi_settings = r_wifi_ff;
   assign rsp_ssid_len         = r_ssid_ff;
   assign rsp_pass_len         = r_pass_ff;

endmodule

`default_nettype wire

### sv/isfp_checker.sv
// isfp_checker: port-level assertions for the serial frame parser.
// Depends on isfp_pkg event codes; bound to improv_serial_frame_parser.
`default_nettype none

module isfp_checker
   import isfp_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic              rsp_accepted,
   input wire logic [EVT_W-1:0]  rsp_frame_event,
   input wire logic              rsp_payload_valid,
   input wire logic [BYTE_W-1:0] rsp_payload_offset,
   input wire logic              rsp_is_wifi_settings
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame_event)
         && $stable(rsp_accepted) && $stable(rsp_payload_offset))
      else $error("stalled result changed");

   // a payload byte always advances the frame and never ends it
   a_payload_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload_valid |-> rsp_accepted && rsp_frame_event == EVT_NONE)
      else $error("payload byte not accepted or carries an event");

   // checksum error and too-long events carry no accept flag
   a_evt_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_frame_event == EVT_CSUM_ERR || rsp_frame_event == EVT_TOO_LONG)
         |-> !rsp_accepted)
      else $error("rejecting event with accept set");

   // WiFi settings only on a good RPC frame
   a_wifi_rpc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_wifi_settings |-> rsp_frame_event == EVT_RPC_OK && rsp_accepted)
      else $error("wifi settings flag without good RPC");

   // offset is zero outside the payload
   a_off_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload_valid |-> rsp_payload_offset == BYTE_ZERO)
      else $error("payload offset set outside payload");

endmodule

bind improv_serial_frame_parser isfp_checker u_isfp_checker (.*);

`default_nettype wire
